// ===== src/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8d_pkg;

    localparam int COUNT_BITS_DEF = 16;     // default width of the character counter
    localparam int CP_W           = 31;     // code point width
    localparam int LEN_W          = 3;      // sequence length width
    localparam int CNT_OUT_W      = 16;     // char_count port width

    // Byte ranges and overlong bounds
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] ASCII_MAX     = 8'h7F;
    localparam logic [7:0] LEAD2_MIN     = 8'hC2;
    localparam logic [7:0] LEAD2_MAX     = 8'hDF;
    localparam logic [7:0] LEAD3_MIN     = 8'hE0;
    localparam logic [7:0] LEAD3_MAX     = 8'hEF;
    localparam logic [7:0] LEAD4_MIN     = 8'hF0;
    localparam logic [7:0] LEAD4_MAX     = 8'hF7;
    localparam logic [7:0] LEAD5_MIN     = 8'hF8;
    localparam logic [7:0] LEAD5_MAX     = 8'hFB;
    localparam logic [7:0] LEAD6_MIN     = 8'hFC;
    localparam logic [7:0] LEAD6_MAX     = 8'hFD;
    localparam logic [7:0] CONT_MIN      = 8'h80;
    localparam logic [7:0] CONT_MAX      = 8'hBF;
    localparam logic [7:0] MIN_AFTER_E0  = 8'hA0;
    localparam logic [7:0] MIN_AFTER_F0  = 8'h90;
    localparam logic [7:0] MIN_AFTER_F8  = 8'h88;
    localparam logic [7:0] MIN_AFTER_FC  = 8'h84;

    typedef enum logic [1:0] {
        STAT_CHAR    = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_END     = 2'd2
    } status_t;

    // Lead byte classification
    typedef struct packed {
        logic             ok;        // a legal lead byte
        logic [LEN_W-1:0] total;     // sequence length 1..6, 0 for an illegal lead
        logic [6:0]       init_val;  // payload bits carried by the lead
        logic [7:0]       min2;      // lower bound for the second byte
    } lead_info_t;

    // One result transfer
    typedef struct packed {
        logic [CP_W-1:0]      code_point;
        logic [LEN_W-1:0]     seq_length;
        status_t              status;
        logic [CNT_OUT_W-1:0] char_count;
    } result_t;

endpackage

// ===== src/utf8d_lead_decode.sv =====
// Lead byte classifier: sequence length, initial payload bits, overlong bound.
// Depends on utf8d_pkg.
module utf8d_lead_decode (
    input  logic [7:0]             lead_byte,
    output utf8d_pkg::lead_info_t  info
);
    import utf8d_pkg::*;

    always_comb
    begin
        info.ok       = 1'b1;
        info.total    = 3'd1;
        info.init_val = 7'(lead_byte & ASCII_MAX);
        info.min2     = CONT_MIN;
        unique case (lead_byte) inside
            [BYTE_ZERO:ASCII_MAX]:
            begin
                info.total    = 3'd1;
                info.init_val = lead_byte[6:0];
            end
            [LEAD2_MIN:LEAD2_MAX]:
            begin
                info.total    = 3'd2;
                info.init_val = {2'b00, lead_byte[4:0]};
            end
            [LEAD3_MIN:LEAD3_MAX]:
            begin
                info.total    = 3'd3;
                info.init_val = {3'b000, lead_byte[3:0]};
                info.min2     = (lead_byte == LEAD3_MIN) ? MIN_AFTER_E0 : CONT_MIN;
            end
            [LEAD4_MIN:LEAD4_MAX]:
            begin
                info.total    = 3'd4;
                info.init_val = {4'b0000, lead_byte[2:0]};
                info.min2     = (lead_byte == LEAD4_MIN) ? MIN_AFTER_F0 : CONT_MIN;
            end
            [LEAD5_MIN:LEAD5_MAX]:
            begin
                info.total    = 3'd5;
                info.init_val = {5'b00000, lead_byte[1:0]};
                info.min2     = (lead_byte == LEAD5_MIN) ? MIN_AFTER_F8 : CONT_MIN;
            end
            [LEAD6_MIN:LEAD6_MAX]:
            begin
                info.total    = 3'd6;
                info.init_val = {6'b000000, lead_byte[0]};
                info.min2     = (lead_byte == LEAD6_MIN) ? MIN_AFTER_FC : CONT_MIN;
            end
            default:
            begin
                // 80-C1, FE, FF
                info.ok       = 1'b0;
                info.total    = 3'd0;
                info.init_val = 7'd0;
            end
        endcase
    end

endmodule

// ===== src/utf8d_step.sv =====
// Sequence state and per-byte update: merges continuation bytes, checks
// ranges, keeps the skip flag and the saturating character count.
// Depends on utf8d_pkg and utf8d_lead_decode.
module utf8d_step #(
    parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,      // byte is consumed this cycle
    input  logic [7:0]          cur_byte,
    output logic                has_result,
    output utf8d_pkg::result_t  result
);
    import utf8d_pkg::*;

    localparam int EXT_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

    logic [LEN_W-1:0]      bytes_left_reg,  bytes_left_next;
    logic [LEN_W-1:0]      seq_total_reg,   seq_total_next;
    logic [7:0]            second_min_reg,  second_min_next;
    logic [CP_W-1:0]       value_accum_reg, value_accum_next;
    logic                  skip_reg,        skip_next;
    logic [COUNT_BITS-1:0] count_reg,       count_next;

    lead_info_t            lead;
    logic [CP_W-1:0]       merged;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] count_shown;
    logic [EXT_W-1:0]      count_ext;

    utf8d_lead_decode u_lead (
        .lead_byte (cur_byte),
        .info      (lead)
    );

    assign merged    = {value_accum_reg[CP_W-7:0], cur_byte[5:0]};
    assign count_inc = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg
                                                         : count_reg + 1'b1;
    assign count_ext = EXT_W'(count_shown);

    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        seq_total_next   = seq_total_reg;
        second_min_next  = second_min_reg;
        value_accum_next = value_accum_reg;
        skip_next        = skip_reg;
        count_next       = count_reg;
        count_shown      = count_reg;
        has_result        = 1'b0;
        result.code_point = '0;
        result.seq_length = '0;
        result.status     = STAT_INVALID;

        if (cur_byte == BYTE_ZERO)
        begin
            // end of string: zero mid-sequence is an error, else an end marker
            has_result    = 1'b1;
            result.status = (!skip_reg && bytes_left_reg != '0) ? STAT_INVALID
                                                                  : STAT_END;
            bytes_left_next  = '0;
            seq_total_next   = '0;
            second_min_next  = CONT_MIN;
            value_accum_next = '0;
            skip_next        = 1'b0;
            count_next       = '0;
        end
        else if (skip_reg)
        begin
            // discard until the zero byte
        end
        else if (bytes_left_reg != '0)
        begin
            if (cur_byte < second_min_reg || cur_byte > CONT_MAX)
            begin
                has_result       = 1'b1;
                result.status    = STAT_INVALID;
                bytes_left_next  = '0;
                seq_total_next   = '0;
                second_min_next  = CONT_MIN;
                value_accum_next = '0;
                skip_next        = 1'b1;
            end
            else if (bytes_left_reg == 3'd1)
            begin
                has_result        = 1'b1;
                result.status     = STAT_CHAR;
                result.code_point = merged;
                result.seq_length = seq_total_reg;
                count_next        = count_inc;
                count_shown       = count_inc;
                bytes_left_next   = '0;
                seq_total_next    = '0;
                second_min_next   = CONT_MIN;
                value_accum_next  = '0;
            end
            else
            begin
                value_accum_next = merged;
                second_min_next  = CONT_MIN;
                bytes_left_next  = bytes_left_reg - 1'b1;
            end
        end
        else if (!lead.ok)
        begin
            has_result       = 1'b1;
            result.status    = STAT_INVALID;
            bytes_left_next  = '0;
            seq_total_next   = '0;
            second_min_next  = CONT_MIN;
            value_accum_next = '0;
            skip_next        = 1'b1;
        end
        else if (lead.total == 3'd1)
        begin
            has_result        = 1'b1;
            result.status     = STAT_CHAR;
            result.code_point = CP_W'(lead.init_val);
            result.seq_length = 3'd1;
            count_next        = count_inc;
            count_shown       = count_inc;
        end
        else
        begin
            seq_total_next   = lead.total;
            bytes_left_next  = lead.total - 1'b1;
            value_accum_next = CP_W'(lead.init_val);
            second_min_next  = lead.min2;
        end

        result.char_count = count_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            seq_total_reg   <= '0;
            second_min_reg  <= CONT_MIN;
            value_accum_reg <= '0;
            skip_reg        <= 1'b0;
            count_reg       <= '0;
        end
        else if (commit)
        begin
            bytes_left_reg  <= bytes_left_next;
            seq_total_reg   <= seq_total_next;
            second_min_reg  <= second_min_next;
            value_accum_reg <= value_accum_next;
            skip_reg        <= skip_next;
            count_reg       <= count_next;
        end
    end

endmodule

// ===== src/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder (1 to 6 byte forms).
// Depends on utf8d_pkg, utf8d_step (which uses utf8d_lead_decode).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | in_valid / in_ready | data_byte[7:0]
//  result  | out       | out_valid/out_ready | code_point[30:0], seq_length[2:0],
//          |           |                     | status[1:0], char_count[15:0]
//
// One byte per cycle, sustained, unless a result is stalled. A byte is
// transferred into the input register; from there the step logic
// updates the sequence state and loads the result register, which
// drives result valid. The state update is combinational logic
// on the step registers (range compare, 6-bit shift-merge, counter increment).
// Reset (rst_n low, asynchronous) empties both registers and returns the
// decoder to the start of a string with a zero count.
// A stalled result only blocks bytes that would produce another result;
// bytes that only advance a sequence or are being discarded keep flowing.
module utf8_stream_decoder #(
    parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [utf8d_pkg::CP_W-1:0]       code_point,
    output logic [utf8d_pkg::LEN_W-1:0]      seq_length,
    output logic [1:0]                       status,
    output logic [utf8d_pkg::CNT_OUT_W-1:0]  char_count
);
    import utf8d_pkg::*;

    // input register
    logic       in_full_reg;
    logic [7:0] byte_reg;

    // result register
    logic       out_full_reg;
    result_t    result_reg;

    logic       step_has_result;
    result_t    step_result;
    logic       out_free;
    logic       advance;

    utf8d_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (advance),
        .cur_byte   (byte_reg),
        .has_result (step_has_result),
        .result     (step_result)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_full_reg || out_ready;
    // buffered byte moves on unless its result has nowhere to go
    assign advance  = in_full_reg && (out_free || !step_has_result);
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_full_reg <= advance && step_has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_has_result && out_free)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_full_reg;
    assign code_point = result_reg.code_point;
    assign seq_length = result_reg.seq_length;
    assign status     = result_reg.status;
    assign char_count = result_reg.char_count;

endmodule
